// ===== rtl/numeric_string_parser_assert.svh =====
// Assertion macros of the numeric string parser checker.
`ifndef NUMERIC_STRING_PARSER_ASSERT_SVH
`define NUMERIC_STRING_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define NSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("numeric_string_parser: assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define NSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("numeric_string_parser: assertion failed");

`endif

// ===== rtl/nsp_pkg.sv =====
// Shared types and constants of the numeric string parser.
package nsp_pkg;

  localparam logic [7:0] CharNul  = 8'h00;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharLowX = 8'h78;
  localparam logic [7:0] CharLowO = 8'h6F;
  localparam logic [7:0] CharLowA = 8'h61;
  localparam logic [7:0] CharUpA  = 8'h41;

  localparam logic [4:0] RadixOct = 5'd8;
  localparam logic [4:0] RadixDec = 5'd10;
  localparam logic [4:0] RadixHex = 5'd16;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusBadChar  = 2'd1,
    StatusBadDigit = 2'd2
  } status_e;

  // Classification of one character.
  typedef struct packed {
    logic       is_alnum;
    logic [5:0] digit;
  } char_class_t;

endpackage

// ===== rtl/nsp_char_decode.sv =====
// Character classifier: maps a character to its digit value 0 to 35.
module nsp_char_decode import nsp_pkg::*; (
  input  logic [7:0]  ch_i,
  output char_class_t class_o
);

  logic [7:0] off_num;
  logic [7:0] off_low;
  logic [7:0] off_up;

  assign off_num = ch_i - CharZero;
  assign off_low = ch_i - CharLowA + 8'd10;
  assign off_up  = ch_i - CharUpA + 8'd10;

  always_comb begin
    class_o.is_alnum = 1'b1;
    class_o.digit    = 6'd0;
    if (ch_i inside {[8'h30:8'h39]}) begin
      class_o.digit = off_num[5:0];
    end else if (ch_i inside {[8'h61:8'h7A]}) begin
      class_o.digit = off_low[5:0];
    end else if (ch_i inside {[8'h41:8'h5A]}) begin
      class_o.digit = off_up[5:0];
    end else begin
      class_o.is_alnum = 1'b0;
    end
  end

endmodule

// ===== rtl/numeric_string_parser.sv =====
// Top level of the numeric string parser: string words in, one value per string out.
//
// The block reads a string one character word per cycle and converts it to an
// unsigned number. A leading "0x" selects base 16, a leading "0o" selects base 8,
// and any other string is read in base 10; letters of either case count as
// digits 10 to 35. A NUL word ends the string and produces exactly one result
// word carrying the value and a status (0 ok, 1 invalid character, 2 digit not
// below the base). The first error is kept until the NUL and forces the value to
// zero. The accumulator is VALUE_WIDTH bits wide and wraps like C unsigned
// arithmetic; the reported value is its low 32 bits, zero-extended when
// VALUE_WIDTH is smaller. A new character is accepted in every cycle unless the
// input stalls: each word passes an input register, then combinational
// classification and a shift-and-add multiply-accumulate (times 8, 10 or 16 plus
// the digit), which is the path that sets the rate. A NUL passes the input
// register, and its result word is then loaded into the result register. The
// result register decouples the two sides, so input only stalls when a NUL
// reaches the processing stage while an earlier result is still stalled at
// the output.
module numeric_string_parser import nsp_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic [1:0]  status_o
);

  // Input register stage.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] ch_q;
  logic       in_accept;
  logic       s1_is_nul;
  logic       s1_go;

  // Parse state.
  logic [VALUE_WIDTH-1:0] accum_q, accum_d;
  logic [4:0]             radix_q, radix_d;
  logic [1:0]             count_q, count_d;
  logic                   saw_zero_q, saw_zero_d;
  status_e                err_q, err_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] value_q;
  status_e     status_q;
  logic        out_load;

  char_class_t            cls;
  logic [VALUE_WIDTH-1:0] scaled;
  logic [VALUE_WIDTH-1:0] digit_ext;
  logic [VALUE_WIDTH+31:0] accum_wide;
  logic [1:0]             count_inc;

  nsp_char_decode u_decode (
    .ch_i    (ch_q),
    .class_o (cls)
  );

  // A NUL can only move on when the result register is free or draining.
  assign s1_is_nul  = (ch_q == CharNul);
  assign s1_go      = s1_valid_q && (!s1_is_nul || !(out_valid_q && out_stall_i));
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = s1_go && s1_is_nul;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  // Multiply by the radix as shifts, plus one add for base 10.
  always_comb begin
    case (radix_q)
      RadixHex: scaled = accum_q << 4;
      RadixOct: scaled = accum_q << 3;
      default:  scaled = (accum_q << 3) + (accum_q << 1);
    endcase
  end

  assign digit_ext = {{(VALUE_WIDTH-6){1'b0}}, cls.digit};
  assign count_inc = (count_q == 2'd2) ? count_q : count_q + 2'd1;

  always_comb begin
    accum_d    = accum_q;
    radix_d    = radix_q;
    count_d    = count_q;
    saw_zero_d = saw_zero_q;
    err_d      = err_q;
    if (s1_go) begin
      if (s1_is_nul) begin
        accum_d    = '0;
        radix_d    = RadixDec;
        count_d    = 2'd0;
        saw_zero_d = 1'b0;
        err_d      = StatusOk;
      end else if (err_q == StatusOk) begin
        if (count_q == 2'd0 && ch_q == CharZero) begin
          saw_zero_d = 1'b1;
          count_d    = count_inc;
        end else if (saw_zero_q && count_q == 2'd1 && ch_q == CharLowX) begin
          radix_d = RadixHex;
          count_d = count_inc;
        end else if (saw_zero_q && count_q == 2'd1 && ch_q == CharLowO) begin
          radix_d = RadixOct;
          count_d = count_inc;
        end else if (!cls.is_alnum) begin
          err_d   = StatusBadChar;
          accum_d = '0;
        end else if (cls.digit >= {1'b0, radix_q}) begin
          err_d   = StatusBadDigit;
          accum_d = '0;
        end else begin
          accum_d = scaled + digit_ext;
          count_d = count_inc;
        end
      end
    end
  end

  // The result word is held until the consumer stops stalling.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign accum_wide = {32'd0, accum_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      accum_q     <= '0;
      radix_q     <= RadixDec;
      count_q     <= 2'd0;
      saw_zero_q  <= 1'b0;
      err_q       <= StatusOk;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      accum_q     <= accum_d;
      radix_q     <= radix_d;
      count_q     <= count_d;
      saw_zero_q  <= saw_zero_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q <= ch_i;
    end
    if (out_load) begin
      value_q  <= (err_q == StatusOk) ? accum_wide[31:0] : 32'd0;
      status_q <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

// ===== rtl/nsp_checker.sv =====
// Port-level checker of the numeric string parser, bound to the top level.
`include "numeric_string_parser_assert.svh"

module nsp_checker import nsp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  ch_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] value_o,
  input logic [1:0]  status_o
);

  // A failed parse always reports a zero value, and no status beyond the known ones.
  `NSP_ASSERT_NOW(a_err_zero, out_valid_o && status_o != StatusOk, value_o == 32'd0)
  `NSP_ASSERT_NOW(a_status_known, out_valid_o, status_o != 2'd3)

  // With no result pending the input side never stalls.
  `NSP_ASSERT_NOW(a_no_idle_stall, !out_valid_o, !in_stall_o)

  // A fresh result word follows a NUL accepted at the input and passed through the input register.
  `NSP_ASSERT_NOW(a_result_cause, $rose(out_valid_o),
                  $past(in_valid_i && !in_stall_o && ch_i == CharNul, 2))

  // A stalled result word holds.
  `NSP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(value_o) && $stable(status_o))

endmodule

bind numeric_string_parser nsp_checker u_nsp_checker (.*);

// ===== tb/sv/tb_numeric_string_parser.sv =====
// Self-checking testbench for the numeric string parser, with a scoreboard and randomized stalls.
`timescale 1ns / 100ps

module tb_numeric_string_parser;
  import nsp_pkg::*;

  // Marks a character that is neither a decimal digit nor a letter.
  localparam logic [5:0] NotDigit = 6'h3F;
  // No new random string is started once this many character words have been accepted.
  localparam int unsigned CharBudget = 1900;

  // Tracks the parse of the current string and holds the results still due at the output.
  class nsp_scoreboard;
    logic [31:0] accum;
    logic [4:0]  radix;
    int unsigned char_count;
    bit          lead_zero;
    status_e     first_error;
    logic [31:0] due_value_q[$];
    status_e     due_status_q[$];
    int unsigned errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      accum       = '0;
      radix       = RadixDec;
      char_count  = 0;
      lead_zero   = 1'b0;
      first_error = StatusOk;
    endfunction

    function void bump();
      if (char_count < 2) char_count++;
    endfunction

    function logic [5:0] digit_value(logic [7:0] c);
      if (c >= CharZero && c <= CharZero + 8'd9) return 6'(c - CharZero);
      if (c >= CharLowA && c <= CharLowA + 8'd25) return 6'(c - CharLowA + 8'd10);
      if (c >= CharUpA && c <= CharUpA + 8'd25) return 6'(c - CharUpA + 8'd10);
      return NotDigit;
    endfunction

    // Advances the parse by one accepted character word.
    function void note_char(logic [7:0] c);
      logic [5:0] d;
      if (c == CharNul) begin
        due_value_q.push_back(first_error != StatusOk ? 32'd0 : accum);
        due_status_q.push_back(first_error);
        restart();
        return;
      end
      // After the first error everything up to the NUL is dropped.
      if (first_error != StatusOk) return;
      if (char_count == 0 && c == CharZero) begin
        lead_zero = 1'b1;
        bump();
        return;
      end
      // Only a lowercase x or o right after the leading zero picks the base.
      if (lead_zero && char_count == 1 && (c == CharLowX || c == CharLowO)) begin
        radix = (c == CharLowX) ? RadixHex : RadixOct;
        bump();
        return;
      end
      d = digit_value(c);
      if (d == NotDigit) begin
        first_error = StatusBadChar;
        accum       = '0;
      end else if (d >= 6'(radix)) begin
        first_error = StatusBadDigit;
        accum       = '0;
      end else begin
        accum = accum * 32'(radix) + 32'(d);
        bump();
      end
    endfunction

    // Compares one accepted result word with the oldest one due.
    function void check_result(logic [31:0] v, logic [1:0] s);
      logic [31:0] want_value;
      status_e     want_status;
      if (due_value_q.size() == 0) begin
        $display("%0t: result with none due, value %h status %0d", $time, v, s);
        errors++;
        return;
      end
      want_value  = due_value_q.pop_front();
      want_status = due_status_q.pop_front();
      if (v !== want_value) begin
        $display("%0t: value mismatch, expected %h actual %h", $time, want_value, v);
        errors++;
      end
      if (s !== want_status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, want_status, s);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due_value_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  ch = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] value;
  logic [1:0]  status;

  nsp_scoreboard sb = new();
  int unsigned   chars_sent = 0;

  numeric_string_parser dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .ch_i       (ch),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .value_o    (value),
    .status_o   (status)
  );

  always #1 clk = ~clk;

  // Both channels are sampled at the rising edge, before any of this edge's updates land.
  // Input words are noted first so a result can never overtake its own NUL.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_char(ch);
      if (out_valid && !out_stall) sb.check_result(value, status);
    end
  end

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] digit_char(int unsigned d, bit lower);
    if (d < 10) return CharZero + 8'(d);
    return (lower ? CharLowA : CharUpA) + 8'(d - 10);
  endfunction

  // Offers one character word and holds it until it is taken. Valid is only lowered when
  // a gap follows, so a word that goes out back-to-back never sees valid drop.
  task automatic send_char(input logic [7:0] c, input bit burst);
    int unsigned gap;
    in_valid <= 1'b1;
    ch       <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    gap = burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string text);
    foreach (text[i]) send_char(text[i], 1'b0);
    send_char(CharNul, 1'b0);
  endtask

  // Builds one string. Most are well formed in a random base with random digit case; some
  // of those get one bad word spliced in, and the rest are raw byte noise.
  task automatic send_random_string();
    logic [7:0]  s[$];
    logic [7:0]  bad;
    int unsigned kind, mode, base, len, pos;
    bit          burst;
    kind  = $urandom_range(0, 99);
    burst = ($urandom_range(0, 3) == 0);
    if (kind < 82) begin
      mode = $urandom_range(0, 3);
      case (mode)
        1: begin
          base = 16;
          s.push_back(CharZero);
          s.push_back(CharLowX);
        end
        2: begin
          base = 8;
          s.push_back(CharZero);
          s.push_back(CharLowO);
        end
        3: begin
          base = 10;
          s.push_back(CharZero);
        end
        default: base = 10;
      endcase
      // Long strings are what push the accumulator past 32 bits.
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6);
      repeat (len) s.push_back(digit_char($urandom_range(0, base - 1),
                                          $urandom_range(0, 1) == 1));
      if (kind >= 64) begin
        case ($urandom_range(0, 2))
          0: bad = 8'($urandom_range(1, 255));
          1: bad = $urandom_range(0, 1) ? CharUpA + 8'd23 : CharUpA + 8'd14;
          default: bad = digit_char($urandom_range(base, 35), $urandom_range(0, 1) == 1);
        endcase
        pos = $urandom_range(0, s.size());
        s.insert(pos, bad);
      end
    end else begin
      len = $urandom_range(0, 8);
      repeat (len) s.push_back(8'($urandom_range(1, 255)));
    end
    s.push_back(CharNul);
    foreach (s[i]) send_char(s[i], burst);
  endtask

  // Stimulus: reset, a directed set of corner strings, then random strings, then drain.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("");          // empty string
    send_text("0x");        // lone hex prefix
    send_text("0o7");       // octal prefix with one digit
    send_text("0X");        // uppercase X is the digit 33, too big in base 10
    send_text("0O");        // uppercase O is the digit 24
    send_text("1x");        // x without a leading zero is just a letter
    send_text("0o8");       // digit at the base
    send_text("9");         // largest decimal digit
    send_text("!z");        // bad character first, the later bad digit is not reported
    send_char(8'h7A, 1'b0); // bad digit first, then a non-ASCII byte with all bits set
    send_char(8'hFF, 1'b0);
    send_char(CharNul, 1'b0);
    send_char(8'h80, 1'b0); // lowest non-ASCII byte on its own
    send_char(CharNul, 1'b0);

    while (chars_sent < CharBudget) send_random_string();
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // Let a stray extra result show up before the verdict.
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random stall stretches. One long hold early on, and a rare one later, let
  // the result register fill so the block has to stall the character words behind it.
  initial begin
    int unsigned span, turns;
    turns = 0;
    @(posedge rst_n);
    forever begin
      turns++;
      if (turns == 30 || $urandom_range(0, 149) == 0) begin
        out_stall <= 1'b1;
        span = $urandom_range(60, 120);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 16);
      end
      repeat (span) @(posedge clk);
    end
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
